// ===== hw/rtl/sss_pkg.sv =====
package sss_pkg;

    localparam int STEPS      = 32;
    localparam int MAX_STRIDE = 8;

    localparam int POS_W = $clog2(STEPS);
    localparam int LEN_W = POS_W + 1;
    localparam int STR_W = $clog2(MAX_STRIDE + 1);
    localparam int MAG_W = $clog2(STEPS + MAX_STRIDE);
    localparam int CNT_W = $clog2(MAG_W);

    localparam int FUNC_W     = 2;
    localparam int MODE_W     = 2;
    localparam int VOLT_W     = 15;
    localparam int SUM_W      = VOLT_W + 2;
    localparam int LKNOB_W    = 14;
    localparam int SKNOB_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;

    // fixed point for length and stride: one step is FULL_SCALE fine units
    localparam int FULL_SCALE  = 10240;
    localparam int SUB_STEP    = 256;
    localparam int KNOB_GAIN   = FULL_SCALE / SUB_STEP;
    localparam int FINE_W      = 22;
    localparam int FINE_LO     = FULL_SCALE;
    localparam int LEN_FINE_HI = STEPS * FULL_SCALE;
    localparam int STR_FINE_HI = MAX_STRIDE * FULL_SCALE;
    localparam int FINE_HALF   = FULL_SCALE / 2;
    localparam int RND_SHIFT   = 10;
    localparam int Z_W         = 10;
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_W     = 8;
    localparam int DIV10_SHIFT = 11;
    localparam int PROD_W      = Z_W + DIV10_W;

    localparam logic [FUNC_W-1:0] FUNC_RISE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FALL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BWD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DIR_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_KNOB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STR_KNOB  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH  = 3'd5;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [LEN_W-1:0] modulus;
    } t_wrap_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] pos;
    } t_wrap_rsp;

endpackage

// ===== hw/rtl/sss_wrap.sv =====
module sss_wrap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sss_pkg::t_wrap_req i_req,
    output sss_pkg::t_wrap_rsp o_rsp
);
    import sss_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_rem;
    logic [MAG_W-1:0] r_mag;
    logic [LEN_W-1:0] r_mod;
    logic             r_neg;

    logic [LEN_W-1:0] shifted;
    logic [POS_W-1:0] n_rem;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem, r_mag[MAG_W-1]};
        if (shifted >= r_mod) begin
            n_rem = POS_W'(shifted - r_mod);
        end else begin
            n_rem = POS_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_mag <= i_req.mag;
            r_mod <= i_req.modulus;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
        end
    end

    // negative positions wrap up from the top
    always_comb begin
        o_rsp.done = r_done;
        if (r_neg && (r_rem != '0)) begin
            o_rsp.pos = POS_W'(r_mod - LEN_W'(r_rem));
        end else begin
            o_rsp.pos = r_rem;
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (LEN_W'(o_rsp.pos) < r_mod))
        else $error("wrapped position not below length");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("wrap started while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start && (r_cnt == CNT_W'(MAG_W - 1))) |=> r_done)
        else $error("wrap done missing");

endmodule

// ===== hw/rtl/stride_step_sequencer_core.sv =====
// Step sequencer with a 32-entry step voltage table. Each input transaction
// (tuser selects clock rise, clock fall, position reset or step load) yields
// exactly one output transaction with the held voltage, gate and position.
// Fall, reset and load go from acceptance straight to the output state, which
// loads the output register. A rise passes through knob/cv scaling, the stride
// move, a bit-serial modulo that wraps the position into the sequence length,
// a registered read of the step table memory, the transpose and clamp, and the
// output register load. The input is ready again once the result sits in the
// output register; that load waits while a previous result still holds it.
// One transaction is worked at a time; the output register lets the next input
// be accepted while a result waits. Configuration writes are taken every cycle
// and must only be issued while the block is idle.
module stride_step_sequencer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // step_index, step_value, length_cv, length_cv_on, stride_cv, stride_cv_on,
    // transpose_cv, transpose_cv_on, random_bit, zero pad
    input  logic [sss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func
    input  logic [sss_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cv_out, gate_out, position, zero pad
    output logic [sss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KNOB = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    function automatic logic [Z_W-1:0] knob_fine(
        input logic [LKNOB_W-1:0]       knob,
        input logic signed [VOLT_W-1:0] cv,
        input logic                     cv_on,
        input logic signed [FINE_W-1:0] gain,
        input logic signed [FINE_W-1:0] hi
    );
        logic signed [FINE_W-1:0] y;
        y = $signed(FINE_W'(knob)) * FINE_W'(KNOB_GAIN);
        if (cv_on) begin
            y = y + FINE_W'(cv) * gain;
        end
        if (y < FINE_W'(FINE_LO)) begin
            y = FINE_W'(FINE_LO);
        end
        if (y > hi) begin
            y = hi;
        end
        return Z_W'((y + FINE_W'(FINE_HALF)) >>> RND_SHIFT);
    endfunction

    logic [2:0] r_state;
    logic [2:0] n_state;

    // configuration
    logic [MODE_W-1:0]        r_dir_mode;
    logic [LKNOB_W-1:0]       r_len_knob;
    logic [SKNOB_W-1:0]       r_str_knob;
    logic signed [VOLT_W-1:0] r_tr_knob;
    logic signed [VOLT_W-1:0] r_out_low;
    logic signed [VOLT_W-1:0] r_out_high;

    // sequencer state
    logic [POS_W-1:0]         r_pos;
    logic signed [VOLT_W-1:0] r_cv;
    logic                     r_gate;

    // latched input fields
    logic signed [VOLT_W-1:0] r_len_cv;
    logic                     r_len_cv_on;
    logic signed [VOLT_W-1:0] r_str_cv;
    logic                     r_str_cv_on;
    logic signed [VOLT_W-1:0] r_tr_cv;
    logic                     r_tr_cv_on;
    logic                     r_rand;

    logic [Z_W-1:0] r_len_z;
    logic [Z_W-1:0] r_str_z;

    // step table
    logic signed [VOLT_W-1:0] r_table [STEPS];
    logic [STEPS-1:0]         r_tab_vld;
    logic signed [VOLT_W-1:0] r_rd_data;
    logic                     r_rd_vld;

    logic                     r_out_valid;
    logic signed [VOLT_W-1:0] r_out_cv;
    logic                     r_out_gate;
    logic [POS_W-1:0]         r_out_pos;

    logic                     in_xact;
    logic [FUNC_W-1:0]        in_func;
    logic [POS_W-1:0]         in_index;
    logic signed [VOLT_W-1:0] in_value;

    logic [PROD_W-1:0]        len_prod;
    logic [PROD_W-1:0]        str_prod;
    logic [LEN_W-1:0]         seq_len;
    logic [STR_W-1:0]         stride;
    logic signed [MAG_W:0]    moved;

    logic signed [SUM_W-1:0]  volt_sum;
    logic signed [VOLT_W-1:0] volt_clamped;

    t_wrap_req wrap_req;
    t_wrap_rsp wrap_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign in_func       = s_axis_tuser;
    assign in_index      = s_axis_tdata[POS_W-1:0];
    assign in_value      = $signed(s_axis_tdata[19:5]);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_pos, r_out_gate, r_out_cv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_mode <= MODE_FWD;
            r_len_knob <= LKNOB_W'(8192);
            r_str_knob <= SKNOB_W'(256);
            r_tr_knob  <= '0;
            r_out_low  <= -VOLT_W'(FULL_SCALE);
            r_out_high <= VOLT_W'(FULL_SCALE);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DIR_MODE:  r_dir_mode <= i_cfg_data[MODE_W-1:0];
                REG_LEN_KNOB:  r_len_knob <= i_cfg_data[LKNOB_W-1:0];
                REG_STR_KNOB:  r_str_knob <= i_cfg_data[SKNOB_W-1:0];
                REG_TRANSPOSE: r_tr_knob  <= $signed(i_cfg_data);
                REG_OUT_LOW:   r_out_low  <= $signed(i_cfg_data);
                REG_OUT_HIGH:  r_out_high <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // length and stride from fine units: divide by 1024, then by 10
    always_comb begin
        len_prod = PROD_W'(r_len_z) * PROD_W'(DIV10_MUL);
        str_prod = PROD_W'(r_str_z) * PROD_W'(DIV10_MUL);
        seq_len  = LEN_W'(len_prod >> DIV10_SHIFT);
        stride   = STR_W'(str_prod >> DIV10_SHIFT);
    end

    always_comb begin
        case (r_dir_mode)
            MODE_FWD:  moved = $signed((MAG_W+1)'(r_pos)) + $signed((MAG_W+1)'(stride));
            MODE_BWD:  moved = $signed((MAG_W+1)'(r_pos)) - $signed((MAG_W+1)'(stride));
            MODE_RAND: begin
                if (r_rand) begin
                    moved = $signed((MAG_W+1)'(r_pos)) + $signed((MAG_W+1)'(stride));
                end else begin
                    moved = $signed((MAG_W+1)'(r_pos)) - $signed((MAG_W+1)'(stride));
                end
            end
            default:   moved = $signed((MAG_W+1)'(r_pos));
        endcase
        wrap_req.start   = (r_state == S_MOVE);
        wrap_req.neg     = moved[MAG_W];
        wrap_req.mag     = moved[MAG_W] ? MAG_W'(-moved) : MAG_W'(moved);
        wrap_req.modulus = seq_len;
    end

    sss_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (wrap_req),
        .o_rsp   (wrap_rsp)
    );

    // transpose and clamp, high bound first
    always_comb begin
        volt_sum = SUM_W'(r_tr_knob);
        if (r_tr_cv_on) begin
            volt_sum = volt_sum + SUM_W'(r_tr_cv);
        end
        if (r_rd_vld) begin
            volt_sum = volt_sum + SUM_W'(r_rd_data);
        end
        if (volt_sum > SUM_W'(r_out_high)) begin
            volt_sum = SUM_W'(r_out_high);
        end
        if (volt_sum < SUM_W'(r_out_low)) begin
            volt_sum = SUM_W'(r_out_low);
        end
        volt_clamped = VOLT_W'(volt_sum);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    n_state = (in_func == FUNC_RISE) ? S_KNOB : S_OUT;
                end
            end
            S_KNOB: n_state = S_MOVE;
            S_MOVE: n_state = S_WAIT;
            S_WAIT: begin
                if (wrap_rsp.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:  n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cv        <= '0;
            r_gate      <= 1'b0;
            r_tab_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        case (in_func)
                            FUNC_FALL:  r_gate <= 1'b0;
                            FUNC_RESET: r_pos  <= '0;
                            FUNC_LOAD:  r_tab_vld[in_index] <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_WAIT: begin
                    if (wrap_rsp.done) begin
                        r_pos <= wrap_rsp.pos;
                    end
                end
                S_SUM: begin
                    r_cv   <= volt_clamped;
                    r_gate <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_len_cv    <= $signed(s_axis_tdata[34:20]);
            r_len_cv_on <= s_axis_tdata[35];
            r_str_cv    <= $signed(s_axis_tdata[50:36]);
            r_str_cv_on <= s_axis_tdata[51];
            r_tr_cv     <= $signed(s_axis_tdata[66:52]);
            r_tr_cv_on  <= s_axis_tdata[67];
            r_rand      <= s_axis_tdata[68];
        end
        if (r_state == S_KNOB) begin
            r_len_z <= knob_fine(r_len_knob, r_len_cv, r_len_cv_on,
                                 FINE_W'(STEPS), FINE_W'(LEN_FINE_HI));
            r_str_z <= knob_fine(LKNOB_W'(r_str_knob), r_str_cv, r_str_cv_on,
                                 FINE_W'(MAX_STRIDE), FINE_W'(STR_FINE_HI));
        end
        if ((r_state == S_OUT) && (!r_out_valid || m_axis_tready)) begin
            r_out_cv   <= r_cv;
            r_out_gate <= r_gate;
            r_out_pos  <= r_pos;
        end
    end

    // step table memory
    always_ff @(posedge i_clk) begin
        if (in_xact && (in_func == FUNC_LOAD)) begin
            r_table[in_index] <= in_value;
        end
        r_rd_data <= r_table[wrap_rsp.pos];
        r_rd_vld  <= r_tab_vld[wrap_rsp.pos];
    end

    a_load_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xact && (in_func == FUNC_LOAD)) |=> r_tab_vld[$past(in_index)])
        else $error("loaded step not marked valid");

    a_rsp_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wrap_rsp.done |-> (r_state == S_WAIT))
        else $error("wrap response outside wait");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("result left before output register freed");

    a_rise_starts_knob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xact && (in_func == FUNC_RISE)) |=> (r_state == S_KNOB))
        else $error("rise did not start the step");

    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (LEN_W'(r_pos) < seq_len))
        else $error("position outside sequence length");

endmodule
